FILE: hdl/tile_pixel_palette_decoder_macros.svh
// Assertion macros shared by the tile pixel palette decoder.
`ifndef TILE_PIXEL_PALETTE_DECODER_MACROS_SVH
`define TILE_PIXEL_PALETTE_DECODER_MACROS_SVH

// Implication checked at the same edge, masked while in reset.
`define TPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge, consequent at the next.
`define TPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tpd_pkg.sv
// Shared types and codes for the tile pixel palette decoder.
package tpd_pkg;

  // Input item operation codes
  typedef enum logic [2:0] {
    OP_WR_STD   = 3'd0,
    OP_WR_BG    = 3'd1,
    OP_WR_OBJ   = 3'd2,
    OP_BG_ADDR  = 3'd3,
    OP_BG_ROW   = 3'd4,
    OP_OBJ_ADDR = 3'd5,
    OP_OBJ_PIX  = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BG_EXT_ENABLE  = 2'd0,
    CFG_OBJ_EXT_ENABLE = 2'd1,
    CFG_TRANSP_COLOUR  = 2'd2
  } cfg_reg_t;

  // Work kinds carried from the front end to the back end
  localparam logic [2:0] KIND_WR_STD = 3'd0;
  localparam logic [2:0] KIND_WR_BG  = 3'd1;
  localparam logic [2:0] KIND_WR_OBJ = 3'd2;
  localparam logic [2:0] KIND_ADDR   = 3'd3;
  localparam logic [2:0] KIND_ROW    = 3'd4;
  localparam logic [2:0] KIND_PIX    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic        d8;
    logic        hflip;
    logic [3:0]  pal;
    logic [1:0]  slot;
    logic        xodd;
    logic [31:0] addr;   // fetch address, or palette entry index for writes
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic        bg_ext_en;
    logic        obj_ext_en;
    logic [15:0] transp;
  } cfg_t;

  typedef struct packed {
    logic mid_row;    // a row decode has issued some but not all pixels
    logic s1_valid;   // palette read stage holds a result
  } bk_status_t;

endpackage

FILE: hdl/tpd_front.sv
// Front end: takes input items, works out addresses and slots, queues work.
module tpd_front
  import tpd_pkg::*;
#(
  parameter int BG_EXT_SLOTS = 4
) (
  input  logic        q_full,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic        in_depth8,
  input  logic [31:0] in_addr,
  input  logic [9:0]  in_tile_index,
  input  logic [7:0]  in_row_y,
  input  logic [5:0]  in_pixel_x,
  input  logic        in_hflip,
  input  logic        in_vflip,
  input  logic [3:0]  in_pal_select,
  input  logic [1:0]  in_ext_slot,
  input  logic [63:0] in_data,
  output logic        q_push,
  output cmd_t        q_cmd
);

  // Reduce a page number modulo the slot count; for three slots use the
  // fact that every power of four leaves one when divided by three.
  function automatic logic [1:0] mod_slots(input logic [19:0] v);
    logic [6:0] s;
    logic [3:0] t;
    logic [2:0] u;
    logic [1:0] r;
    s = '0;
    t = '0;
    u = '0;
    r = '0;
    if (BG_EXT_SLOTS == 3) begin
      for (int i = 0; i < 5; i++) s = s + 7'(v[4*i +: 4]);
      t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[6]);
      u = 3'(t[1:0]) + 3'(t[3:2]);
      if (u >= 3'd3) u = u - 3'd3;
      r = u[1:0];
    end else begin
      r = v[1:0] & 2'(BG_EXT_SLOTS - 1);
    end
    return r;
  endfunction

  logic [2:0]  row;
  logic [15:0] bg_off;
  logic [13:0] obj_off;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign row      = in_row_y[2:0] ^ {3{in_vflip}};

  always_comb begin
    bg_off  = in_depth8 ? {in_tile_index, row, 3'b000} : {1'b0, in_tile_index, row, 2'b00};
    obj_off = in_depth8 ? {in_row_y, in_pixel_x} : {1'b0, in_row_y, in_pixel_x[5:1]};
  end

  always_comb begin
    q_cmd       = '0;
    q_cmd.d8    = in_depth8;
    q_cmd.hflip = in_hflip;
    q_cmd.pal   = in_pal_select;
    q_cmd.slot  = mod_slots({18'd0, in_ext_slot});
    q_cmd.xodd  = in_pixel_x[0];
    q_cmd.data  = in_data;
    q_cmd.addr  = in_addr;
    q_push      = accept;
    case (in_op)
      OP_WR_STD:  q_cmd.kind = KIND_WR_STD;
      OP_WR_BG: begin
        q_cmd.kind = KIND_WR_BG;
        q_cmd.addr = {18'd0, mod_slots(in_addr[31:12]), in_addr[11:0]};
      end
      OP_WR_OBJ:  q_cmd.kind = KIND_WR_OBJ;
      OP_BG_ADDR: begin
        q_cmd.kind = KIND_ADDR;
        q_cmd.addr = in_addr + 32'(bg_off);
      end
      OP_BG_ROW:  q_cmd.kind = KIND_ROW;
      OP_OBJ_ADDR: begin
        q_cmd.kind = KIND_ADDR;
        q_cmd.addr = in_addr + 32'(obj_off);
      end
      OP_OBJ_PIX: q_cmd.kind = KIND_PIX;
      default:    q_push = 1'b0;   // drop unknown op
    endcase
  end

endmodule

FILE: hdl/tpd_fifo.sv
// Short command queue between the front and back ends.
module tpd_fifo
  import tpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          entry_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = entry_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/tpd_back.sv
// Back end: palette stores, pixel lookups and the result register.
module tpd_back
  import tpd_pkg::*;
#(
  parameter int BG_EXT_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_colour,
  output logic [2:0]  out_column,
  output logic [31:0] out_fetch_address,
  output logic        out_last,
  output bk_status_t  status
);

  localparam int STD_DEPTH = 512;
  localparam int OBJ_DEPTH = 4096;
  localparam int BG_DEPTH  = BG_EXT_SLOTS * 4096;
  localparam int BG_AW     = $clog2(BG_DEPTH);

  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_STD    = 3'd1;
  localparam logic [2:0] SRC_BG     = 3'd2;
  localparam logic [2:0] SRC_OBJ    = 3'd3;
  localparam logic [2:0] SRC_TRANSP = 3'd4;

  logic [15:0] std_mem [STD_DEPTH];
  logic [15:0] bg_mem  [BG_DEPTH];
  logic [15:0] obj_mem [OBJ_DEPTH];
  logic [15:0] std_rd_r, bg_rd_r, obj_rd_r;

  logic [2:0]  k_r, k_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic [2:0]  s1_src_r;
  logic [2:0]  s1_column_r;
  logic [31:0] s1_fetch_r;
  logic        s1_last_r;

  logic        out_valid_r;
  logic [15:0] out_colour_r;
  logic [2:0]  out_column_r;
  logic [31:0] out_fetch_r;
  logic        out_last_r;

  logic        is_row, is_pix, is_res, is_wr;
  logic        out_take, s1_adv, issue, wr;
  logic [2:0]  nib_sel, byte_sel;
  logic [3:0]  nib;
  logic [7:0]  pbyte;
  logic        idx_zero;
  logic [2:0]  src;
  logic [8:0]  std_ra;
  logic [BG_AW-1:0] bg_ra;
  logic [11:0] obj_ra;
  logic [2:0]  column;
  logic        last;
  logic [15:0] colour;

  assign is_row = q_head.kind == KIND_ROW;
  assign is_pix = q_head.kind == KIND_PIX;
  assign is_res = is_row || is_pix || q_head.kind == KIND_ADDR;
  assign is_wr  = q_head.kind == KIND_WR_STD || q_head.kind == KIND_WR_BG ||
                  q_head.kind == KIND_WR_OBJ;

  assign out_take = out_valid_r & ~out_stall;
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_take);
  assign issue    = ~q_empty & is_res & (~s1_valid_r | s1_adv);
  assign wr       = ~q_empty & is_wr;
  // Hold a row at the head of the queue until its eighth pixel issues
  assign q_pop    = wr | (issue & (~is_row | k_r == 3'd7));
  assign k_nxt    = (issue && is_row) ? k_r + 1'b1 : k_r;

  // Pick the palette index for this pixel
  always_comb begin
    nib_sel  = is_row ? k_r : {2'b00, q_head.xodd};
    byte_sel = is_row ? k_r : 3'd0;
    nib      = q_head.data[{nib_sel, 2'b00} +: 4];
    pbyte    = q_head.data[{byte_sel, 3'b000} +: 8];
    idx_zero = q_head.d8 ? (pbyte == 8'd0) : (nib == 4'd0);
    std_ra   = {is_pix, q_head.d8 ? pbyte : {q_head.pal, nib}};
    bg_ra    = BG_AW'({q_head.slot, q_head.pal, pbyte});
    obj_ra   = {q_head.pal, pbyte};
    column   = is_row ? (k_r ^ {3{q_head.hflip}}) : 3'd0;
    last     = is_row ? (k_r == 3'd7) : 1'b1;
    if (!is_row && !is_pix) src = SRC_NONE;
    else if (idx_zero) src = SRC_TRANSP;
    else if (q_head.d8 && is_row && cfg.bg_ext_en) src = SRC_BG;
    else if (q_head.d8 && is_pix && cfg.obj_ext_en) src = SRC_OBJ;
    else src = SRC_STD;
  end

  always_ff @(posedge clk) begin
    if (wr && q_head.kind == KIND_WR_STD) std_mem[q_head.addr[8:0]] <= q_head.data[15:0];
    if (issue && src == SRC_STD) std_rd_r <= std_mem[std_ra];
  end

  always_ff @(posedge clk) begin
    if (wr && q_head.kind == KIND_WR_BG) bg_mem[BG_AW'(q_head.addr)] <= q_head.data[15:0];
    if (issue && src == SRC_BG) bg_rd_r <= bg_mem[bg_ra];
  end

  always_ff @(posedge clk) begin
    if (wr && q_head.kind == KIND_WR_OBJ) obj_mem[q_head.addr[11:0]] <= q_head.data[15:0];
    if (issue && src == SRC_OBJ) obj_rd_r <= obj_mem[obj_ra];
  end

  always_comb begin
    if (issue) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_src_r    <= src;
      s1_column_r <= column;
      s1_fetch_r  <= (q_head.kind == KIND_ADDR) ? q_head.addr : 32'd0;
      s1_last_r   <= last;
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_STD:    colour = std_rd_r;
      SRC_BG:     colour = bg_rd_r;
      SRC_OBJ:    colour = obj_rd_r;
      SRC_TRANSP: colour = cfg.transp;
      default:    colour = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_colour_r <= colour;
      out_column_r <= s1_column_r;
      out_fetch_r  <= s1_fetch_r;
      out_last_r   <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r        <= k_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_colour        = out_colour_r;
  assign out_column        = out_column_r;
  assign out_fetch_address = out_fetch_r;
  assign out_last          = out_last_r;

  assign status.mid_row  = k_r != 3'd0;
  assign status.s1_valid = s1_valid_r;

endmodule

FILE: hdl/tile_pixel_palette_decoder.sv
// Top level of the tile pixel palette decoder.
// The decoder takes one item per cycle into a four-entry queue while the queue is
// not full; the back end pops a palette write, an address item or a sprite pixel
// as it issues, and holds a background row at the head while it issues one pixel
// per cycle as long as results are not stalled, since each palette store has a
// single read port. A result passes the queue, the palette read stage and the output
// register. A stalled result holds only the output and read stages; the queue keeps taking items until full.
// Palette stores are not cleared by reset and must be written before use.
`include "tile_pixel_palette_decoder_macros.svh"
module tile_pixel_palette_decoder
  import tpd_pkg::*;
#(
  parameter int BG_EXT_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic        in_depth8,
  input  logic [31:0] in_addr,
  input  logic [9:0]  in_tile_index,
  input  logic [7:0]  in_row_y,
  input  logic [5:0]  in_pixel_x,
  input  logic        in_hflip,
  input  logic        in_vflip,
  input  logic [3:0]  in_pal_select,
  input  logic [1:0]  in_ext_slot,
  input  logic [63:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_colour,
  output logic [2:0]  out_column,
  output logic [31:0] out_fetch_address,
  output logic        out_last
);

  cfg_t       cfg_r;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_cmd, q_head;
  bk_status_t bk_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_ext_en  <= 1'b0;
      cfg_r.obj_ext_en <= 1'b0;
      cfg_r.transp     <= 16'h8000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BG_EXT_ENABLE:  cfg_r.bg_ext_en  <= cfg_data[0];
        CFG_OBJ_EXT_ENABLE: cfg_r.obj_ext_en <= cfg_data[0];
        CFG_TRANSP_COLOUR:  cfg_r.transp     <= cfg_data;
        default: ;
      endcase
    end
  end

  tpd_front #(.BG_EXT_SLOTS(BG_EXT_SLOTS)) u_front (
    .q_full        (q_full),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_depth8     (in_depth8),
    .in_addr       (in_addr),
    .in_tile_index (in_tile_index),
    .in_row_y      (in_row_y),
    .in_pixel_x    (in_pixel_x),
    .in_hflip      (in_hflip),
    .in_vflip      (in_vflip),
    .in_pal_select (in_pal_select),
    .in_ext_slot   (in_ext_slot),
    .in_data       (in_data),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  tpd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  tpd_back #(.BG_EXT_SLOTS(BG_EXT_SLOTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_colour        (out_colour),
    .out_column        (out_column),
    .out_fetch_address (out_fetch_address),
    .out_last          (out_last),
    .status            (bk_st)
  );

  // A partly issued row must still sit at the head of the queue
  `TPD_ASSERT(a_mid_row_queued, bk_st.mid_row |-> !q_empty, "row decode lost its queue entry")
  // Within a row the next pixel is already read while the current one waits
  `TPD_ASSERT(a_row_follows, (out_valid && !out_last) |-> bk_st.s1_valid, "row pixel gap")
  `TPD_ASSERT(a_addr_clean, (out_valid && out_fetch_address != 32'd0) |->
              (out_last && out_column == 3'd0 && out_colour == 16'd0), "address result has pixels")
  `TPD_ASSERT_NEXT(a_push_lands, (q_push && q_empty), !q_empty, "queued item vanished")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the tile pixel palette decoder.
`timescale 1ns / 100ps

module testbench
  import tpd_pkg::*;
();

  typedef enum int {PAL_STD, PAL_BG, PAL_OBJ} palette_t;

  typedef struct {
    op_t         op;
    bit          depth8;
    bit [31:0]   addr;
    bit [9:0]    tile;
    bit [7:0]    row_y;
    bit [5:0]    pixel_x;
    bit          hflip;
    bit          vflip;
    bit [3:0]    pal;
    bit [1:0]    slot;
    bit [63:0]   data;
  } tile_item_t;

  typedef struct packed {
    logic [15:0] colour;
    logic [2:0]  column;
    logic [31:0] fetch;
    logic        last;
  } pixel_t;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;

  // Holds the palette contents and register copy, and predicts decoded pixels
  class tile_colour_predictor;
    bit [15:0] std_pal[int];
    bit [15:0] bg_pal[int];
    bit [15:0] obj_pal[int];
    bit        bg_ext_en;
    bit        obj_ext_en;
    bit [15:0] transp = 16'h8000;
    pixel_t    pending_pixels[$];
    int        errors;
    int        checked;
    int        ops_seen[8];

    function void set_reg(cfg_reg_t r, bit [15:0] v);
      case (r)
        CFG_BG_EXT_ENABLE:  bg_ext_en = v[0];
        CFG_OBJ_EXT_ENABLE: obj_ext_en = v[0];
        CFG_TRANSP_COLOUR:  transp = v;
        default: ;
      endcase
    endfunction

    function int pixel_count(tile_item_t it);
      if (it.op == OP_BG_ROW) return 8;
      if (it.op == OP_OBJ_PIX) return 1;
      return 0;
    endfunction

    // Returns 1 when pixel k reads a palette entry, and which one
    function bit pixel_source(tile_item_t it, int k, output palette_t p, output int e);
      int idx;
      p = PAL_STD;
      e = 0;
      if (it.op == OP_OBJ_PIX) begin
        if (it.depth8) idx = int'(it.data[7:0]);
        else idx = it.pixel_x[0] ? int'(it.data[7:4]) : int'(it.data[3:0]);
        if (idx == 0) return 0;
        if (it.depth8 && obj_ext_en) begin
          p = PAL_OBJ;
          e = int'(it.pal) * 256 + idx;
        end else if (it.depth8) begin
          e = 256 + idx;
        end else begin
          e = 256 + int'(it.pal) * 16 + idx;
        end
        return 1;
      end
      if (it.depth8) idx = int'((it.data >> (8 * k)) & 64'hff);
      else idx = int'((it.data >> (4 * k)) & 64'hf);
      if (idx == 0) return 0;
      if (it.depth8 && bg_ext_en) begin
        p = PAL_BG;
        e = int'(it.slot) * 4096 + int'(it.pal) * 256 + idx;
      end else if (it.depth8) begin
        e = idx;
      end else begin
        e = int'(it.pal) * 16 + idx;
      end
      return 1;
    endfunction

    function bit written(palette_t p, int e);
      case (p)
        PAL_BG:  return bg_pal.exists(e);
        PAL_OBJ: return obj_pal.exists(e);
        default: return std_pal.exists(e);
      endcase
    endfunction

    function bit [15:0] colour_at(tile_item_t it, int k);
      palette_t p;
      int e;
      if (!pixel_source(it, k, p, e)) return transp;
      case (p)
        PAL_BG:  return bg_pal[e];
        PAL_OBJ: return obj_pal[e];
        default: return std_pal[e];
      endcase
    endfunction

    function void take_item(tile_item_t it);
      pixel_t    px;
      bit [7:0]  row;
      px = '{colour: 16'h0, column: 3'd0, fetch: 32'h0, last: 1'b1};
      ops_seen[it.op]++;
      case (it.op)
        OP_WR_STD: std_pal[int'(it.addr[8:0])] = it.data[15:0];
        OP_WR_BG:  bg_pal[int'(it.addr[13:0])] = it.data[15:0];
        OP_WR_OBJ: obj_pal[int'(it.addr[11:0])] = it.data[15:0];
        OP_BG_ADDR: begin
          row = (it.vflip ? (it.row_y ^ 8'd7) : it.row_y) & 8'd7;
          if (it.depth8) px.fetch = it.addr + 32'(it.tile) * 64 + 32'(row) * 8;
          else px.fetch = it.addr + 32'(it.tile) * 32 + 32'(row) * 4;
          pending_pixels.push_back(px);
        end
        OP_OBJ_ADDR: begin
          if (it.depth8) px.fetch = it.addr + 32'(it.row_y) * 64 + 32'(it.pixel_x);
          else px.fetch = it.addr + 32'(it.row_y) * 32 + 32'(it.pixel_x >> 1);
          pending_pixels.push_back(px);
        end
        OP_BG_ROW: begin
          for (int k = 0; k < 8; k++) begin
            px.colour = colour_at(it, k);
            px.column = it.hflip ? 3'(k ^ 7) : 3'(k);
            px.last   = (k == 7);
            pending_pixels.push_back(px);
          end
        end
        OP_OBJ_PIX: begin
          px.colour = colour_at(it, 0);
          pending_pixels.push_back(px);
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: colour %h column %0d fetch %h last %0d",
               got.colour, got.column, got.fetch, got.last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.colour !== want.colour) begin
        $error("colour: expected %h, got %h", want.colour, got.colour);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("column: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      if (got.fetch !== want.fetch) begin
        $error("fetch_address: expected %h, got %h", want.fetch, got.fetch);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = 3'd0;
  logic        in_depth8 = 1'b0;
  logic [31:0] in_addr = 32'h0;
  logic [9:0]  in_tile_index = 10'h0;
  logic [7:0]  in_row_y = 8'h0;
  logic [5:0]  in_pixel_x = 6'h0;
  logic        in_hflip = 1'b0;
  logic        in_vflip = 1'b0;
  logic [3:0]  in_pal_select = 4'h0;
  logic [1:0]  in_ext_slot = 2'd0;
  logic [63:0] in_data = 64'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_colour;
  logic [2:0]  out_column;
  logic [31:0] out_fetch_address;
  logic        out_last;

  tile_colour_predictor decoded = new();

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  tile_pixel_palette_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_depth8         (in_depth8),
    .in_addr           (in_addr),
    .in_tile_index     (in_tile_index),
    .in_row_y          (in_row_y),
    .in_pixel_x        (in_pixel_x),
    .in_hflip          (in_hflip),
    .in_vflip          (in_vflip),
    .in_pal_select     (in_pal_select),
    .in_ext_slot       (in_ext_slot),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_colour        (out_colour),
    .out_column        (out_column),
    .out_fetch_address (out_fetch_address),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check accepted pixels, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      decoded.check_pixel('{out_colour, out_column, out_fetch_address, out_last});
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, decoded.pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(tile_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= it.op;
    in_depth8     <= it.depth8;
    in_addr       <= it.addr;
    in_tile_index <= it.tile;
    in_row_y      <= it.row_y;
    in_pixel_x    <= it.pixel_x;
    in_hflip      <= it.hflip;
    in_vflip      <= it.vflip;
    in_pal_select <= it.pal;
    in_ext_slot   <= it.slot;
    in_data       <= it.data;
    do @(posedge clk); while (!(in_valid && !in_stall));
    decoded.take_item(it);
  endtask

  function automatic bit [63:0] pixel_data();
    bit [63:0] d;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 3))
        0: d[b*8 +: 8] = 8'h00;
        1: d[b*8 +: 8] = 8'h11;
        2: d[b*8 +: 8] = 8'hff;
        default: d[b*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return d;
  endfunction

  function automatic tile_item_t random_item();
    tile_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) it.op = OP_NONE;
    else if (r < 18) it.op = op_t'($urandom_range(0, 2));
    else if (r < 36) it.op = $urandom_range(0, 1) ? OP_BG_ADDR : OP_OBJ_ADDR;
    else if (r < 70) it.op = OP_BG_ROW;
    else it.op = OP_OBJ_PIX;
    it.depth8  = 1'($urandom_range(0, 1));
    it.addr    = $urandom;
    it.tile    = 10'($urandom_range(0, 1023));
    it.row_y   = 8'($urandom_range(0, 255));
    it.pixel_x = 6'($urandom_range(0, 63));
    it.hflip   = 1'($urandom_range(0, 1));
    it.vflip   = 1'($urandom_range(0, 1));
    it.pal     = 4'($urandom_range(0, 15));
    it.slot    = 2'($urandom_range(0, 3));
    it.data    = (it.op == OP_BG_ROW || it.op == OP_OBJ_PIX) ? pixel_data()
                                                              : {$urandom, $urandom};
    return it;
  endfunction

  function automatic tile_item_t plain(op_t op, bit d8);
    tile_item_t it;
    it = '{op: op, depth8: d8, default: '0};
    return it;
  endfunction

  // Write any palette entry the item will read that holds no value yet, then send it
  task automatic send_decoded(tile_item_t it);
    tile_item_t w;
    palette_t   p;
    int         e;
    for (int k = 0; k < decoded.pixel_count(it); k++) begin
      if (decoded.pixel_source(it, k, p, e) && !decoded.written(p, e)) begin
        w = random_item();
        w.data = {$urandom, $urandom};
        case (p)
          PAL_BG: begin
            w.op = OP_WR_BG;
            w.addr[13:0] = e[13:0];
          end
          PAL_OBJ: begin
            w.op = OP_WR_OBJ;
            w.addr[11:0] = e[11:0];
          end
          default: begin
            w.op = OP_WR_STD;
            w.addr[8:0] = e[8:0];
          end
        endcase
        send_item(w);
      end
    end
    send_item(it);
  endtask

  // Drop valid, wait for every expected pixel, then let queued writes retire
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t r, bit [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    decoded.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic run_phase(bit bg, bit obj, bit [15:0] tr, int send_idle, int recv_stall,
                           int count);
    set_reg(CFG_BG_EXT_ENABLE, 16'(bg));
    set_reg(CFG_OBJ_EXT_ENABLE, 16'(obj));
    set_reg(CFG_TRANSP_COLOUR, tr);
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    repeat (count) send_decoded(random_item());
    settle();
  endtask

  initial begin
    tile_item_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Address extremes, wrapping past 32 bits, both depths and a vertical flip
    send_decoded(plain(OP_BG_ADDR, 1'b0));
    it = plain(OP_BG_ADDR, 1'b1);
    it.addr = 32'hffff_ffff;
    it.tile = 10'h3ff;
    it.row_y = 8'hff;
    it.vflip = 1'b1;
    send_decoded(it);
    it.depth8 = 1'b0;
    it.vflip = 1'b0;
    it.row_y = 8'd5;
    send_decoded(it);
    it = plain(OP_OBJ_ADDR, 1'b0);
    it.addr = 32'hffff_ffff;
    it.row_y = 8'hff;
    it.pixel_x = 6'h3f;
    send_decoded(it);
    it.depth8 = 1'b1;
    send_decoded(it);

    // Row decode: all transparent, all top index with mirror, mixed lanes
    send_decoded(plain(OP_BG_ROW, 1'b0));
    it = plain(OP_BG_ROW, 1'b0);
    it.data = '1;
    it.pal = 4'hf;
    it.hflip = 1'b1;
    send_decoded(it);
    it = plain(OP_BG_ROW, 1'b0);
    it.data = 64'hffff_ffff_7654_3210;
    send_decoded(it);
    it.depth8 = 1'b1;
    it.data = 64'hff00_8001_7f10_0201;
    send_decoded(it);

    // Sprite pixels: odd and even column nibbles, index zero, 8bpp extremes
    it = plain(OP_OBJ_PIX, 1'b0);
    it.pixel_x = 6'd1;
    it.pal = 4'hf;
    it.data = 64'hf0;
    send_decoded(it);
    it.pixel_x = 6'd62;
    it.data = 64'h0f;
    send_decoded(it);
    it.pixel_x = 6'd63;
    send_decoded(it);
    it = plain(OP_OBJ_PIX, 1'b1);
    it.data = 64'hff;
    send_decoded(it);
    it.data = 64'h0;
    send_decoded(it);

    // Unknown op must vanish without a result
    it = plain(OP_NONE, 1'b1);
    it.addr = '1;
    it.data = '1;
    send_decoded(it);
    settle();

    // Extended palettes on, every background slot
    set_reg(CFG_BG_EXT_ENABLE, 16'd1);
    set_reg(CFG_OBJ_EXT_ENABLE, 16'd1);
    set_reg(CFG_TRANSP_COLOUR, 16'hffff);
    for (int s = 0; s < 4; s++) begin
      it = plain(OP_BG_ROW, 1'b1);
      it.slot = 2'(s);
      it.pal = 4'hf;
      it.hflip = s[0];
      it.data = 64'hff01_0000_0000_0080;
      send_decoded(it);
    end
    it = plain(OP_OBJ_PIX, 1'b1);
    it.pal = 4'hf;
    it.data = 64'hff;
    send_decoded(it);
    send_decoded(plain(OP_BG_ROW, 1'b1));
    it = plain(OP_BG_ROW, 1'b0);
    it.data = 64'h0000_0000_0000_f0f1;
    send_decoded(it);
    settle();

    run_phase(1'b0, 1'b0, 16'h0000, 0, 0, 16);
    run_phase(1'b1, 1'b1, 16'hffff, 63, 0, 16);
    run_phase(1'b1, 1'b0, 16'($urandom), 0, 63, 16);
    run_phase(1'b0, 1'b1, 16'($urandom), 15, 15, 16);
    // Hold the result side off while items keep coming so the input backs up
    hold_req <= 1'b1;
    run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom), 0, 0, 16);
    run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'h8000, 63, 63, 16);

    $display("Sent %0d items: %0d writes, %0d address, %0d row, %0d pixel, %0d unknown",
             decoded.ops_seen[OP_WR_STD] + decoded.ops_seen[OP_WR_BG] +
             decoded.ops_seen[OP_WR_OBJ] + decoded.ops_seen[OP_BG_ADDR] +
             decoded.ops_seen[OP_OBJ_ADDR] + decoded.ops_seen[OP_BG_ROW] +
             decoded.ops_seen[OP_OBJ_PIX] + decoded.ops_seen[OP_NONE],
             decoded.ops_seen[OP_WR_STD] + decoded.ops_seen[OP_WR_BG] +
             decoded.ops_seen[OP_WR_OBJ],
             decoded.ops_seen[OP_BG_ADDR] + decoded.ops_seen[OP_OBJ_ADDR],
             decoded.ops_seen[OP_BG_ROW], decoded.ops_seen[OP_OBJ_PIX],
             decoded.ops_seen[OP_NONE]);
    $display("Checked %0d results: eight register setups, idle mixes, a %0d-cycle hold-off",
             decoded.checked, HOLD_CYCLES);
    if (decoded.errors == 0 && decoded.pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tpd_pkg.sv
hdl/tpd_front.sv
hdl/tpd_fifo.sv
hdl/tpd_back.sv
hdl/tile_pixel_palette_decoder.sv
tb/testbench.sv
